>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the gradient noise block.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gn3d_pkg.sv
// Shared types, constants and arithmetic helpers for the gradient noise block.
// No dependencies.
`default_nettype none

package gn3d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int OFFSET_W  = 24;
    localparam int FRAC_W    = FRAC_BITS;
    localparam int FADE_W    = FRAC_BITS + 1;
    localparam int WGT_W     = FRAC_BITS + 4;
    localparam int DELTA_W   = FRAC_BITS + 2;
    localparam int GRAD_W    = FRAC_BITS + 3;
    localparam int VAL_W     = FRAC_BITS + 4;
    localparam int PROD_W    = 2 * FRAC_BITS + 8;
    localparam int NOISE_W   = FRAC_BITS + 3;
    localparam int ONE_FX    = 1 << FRAC_BITS;
    localparam int HALF_FX   = 1 << (FRAC_BITS - 1);

    // Gradient selection thresholds on the low four hash bits.
    localparam logic [3:0] GSEL_A_Y  = 4'd8;
    localparam logic [3:0] GSEL_B_Y  = 4'd4;
    localparam logic [3:0] GSEL_B_XA = 4'd12;
    localparam logic [3:0] GSEL_B_XB = 4'd14;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    // Dot product of the edge gradient picked by the 4-bit hash h with the corner delta.
    function automatic logic signed [GRAD_W-1:0] grad_dot(
        input logic [3:0]                h,
        input logic signed [DELTA_W-1:0] x,
        input logic signed [DELTA_W-1:0] y,
        input logic signed [DELTA_W-1:0] z
    );
        logic signed [GRAD_W-1:0] a;
        logic signed [GRAD_W-1:0] b;
        a = GRAD_W'((h < GSEL_A_Y) ? x : y);
        if (h < GSEL_B_Y)
            b = GRAD_W'(y);
        else if (h == GSEL_B_XA || h == GSEL_B_XB)
            b = GRAD_W'(x);
        else
            b = GRAD_W'(z);
        return (h[0] ? -a : a) + (h[1] ? -b : b);
    endfunction

    // Drops the fraction bits, rounding half away from zero.
    function automatic logic signed [VAL_W-1:0] round_frac(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] mag;
        logic signed [PROD_W-1:0] qm;
        mag = (p < 0) ? -p : p;
        qm  = (mag + PROD_W'(HALF_FX)) >>> FRAC_BITS;
        return VAL_W'((p < 0) ? -qm : qm);
    endfunction

endpackage

`default_nettype wire

>>> design/gradient_noise_3d.sv
// Top level of the 3D gradient noise block: streaming ports, APB registers, pipeline.
// Depends on gn3d_pkg and assert_macros.svh.
//
//  Channel  | Direction | Carries
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | one command: table load or point evaluation
//  m_*      | out       | one noise value per evaluation
//  APB      | in/out    | offset_x, offset_y, offset_z at 0x0, 0x4, 0x8
//
// Ten register stages; an item may enter in every cycle while the output is not
// stalled; each result leaves from stage 10. The depth is set by the three
// chained table reads (stages 1 to 3), the fade and gradient stages, and three
// multiply-then-round lerp levels. A load takes effect at once for every later
// item and leaves no result. Reset clears valid bits and offsets; the table is
// undefined until loaded. A stalled output holds the pipe; bubbles still close up.
`default_nettype none

`include "assert_macros.svh"

module gradient_noise_3d
    import gn3d_pkg::*;
#(
    parameter int TABLE_SIZE = 256
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [7:0] table_index, [15:8] table_value, [47:16] coord_x,
    // [79:48] coord_y, [111:80] coord_z
    input  wire logic [111:0] s_tdata,
    // [0] command
    input  wire logic         s_tuser,
    // Output stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [18:0] noise, [23:19] zero
    output logic [23:0]       m_tdata,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    // ------------------------------------------------------------------
    // Configuration registers. Write only while the pipe is idle; not enforced.
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] offset_x_reg;
    logic [OFFSET_W-1:0] offset_y_reg;
    logic [OFFSET_W-1:0] offset_z_reg;
    reg_idx_t            reg_sel;
    logic                reg_wr;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (reg_wr)
        begin
            unique case (reg_sel)
                REG_OFFSET_X: offset_x_reg <= pwdata[OFFSET_W-1:0];
                REG_OFFSET_Y: offset_y_reg <= pwdata[OFFSET_W-1:0];
                REG_OFFSET_Z: offset_z_reg <= pwdata[OFFSET_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_OFFSET_X: prdata = 32'(offset_x_reg);
            REG_OFFSET_Y: prdata = 32'(offset_y_reg);
            REG_OFFSET_Z: prdata = 32'(offset_z_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage k advances when it is empty or when the
    // stage after it advances; the output register is stage 10.
    // ------------------------------------------------------------------
    logic [10:1] v_reg;
    logic [11:1] en;

    always_comb
    begin
        en[11] = m_tready;
        for (int k = 10; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign s_tready = en[1];

    // Loads only travel until the last table copy has been written (stage 2).
    cmd_t cmd1_reg;
    cmd_t cmd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[1])  v_reg[1]  <= s_tvalid;
            if (en[2])  v_reg[2]  <= v_reg[1];
            if (en[3])  v_reg[3]  <= v_reg[2] && (cmd2_reg == CMD_EVAL);
            for (int k = 4; k <= 10; k++)
                if (en[k]) v_reg[k] <= v_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 0 (input): add offsets, split into cell index and fraction.
    // ------------------------------------------------------------------
    cmd_t                     cmd0;
    logic [IDX_W-1:0]         ld_idx0;
    logic [7:0]               ld_val0;
    logic signed [COORD_W:0]  sum_x;
    logic signed [COORD_W:0]  sum_y;
    logic signed [COORD_W:0]  sum_z;

    assign cmd0    = cmd_t'(s_tuser);
    assign ld_idx0 = IDX_W'(s_tdata[7:0]);
    assign ld_val0 = s_tdata[15:8];
    assign sum_x   = $signed({s_tdata[47], s_tdata[47:16]})
                   + $signed({(COORD_W + 1 - OFFSET_W)'(0), offset_x_reg});
    assign sum_y   = $signed({s_tdata[79], s_tdata[79:48]})
                   + $signed({(COORD_W + 1 - OFFSET_W)'(0), offset_y_reg});
    assign sum_z   = $signed({s_tdata[111], s_tdata[111:80]})
                   + $signed({(COORD_W + 1 - OFFSET_W)'(0), offset_z_reg});

    logic [IDX_W-1:0] cx0;
    assign cx0 = sum_x[FRAC_BITS +: IDX_W];

    // Stage 1 payload.
    logic [IDX_W-1:0]  ld_idx1_reg;
    logic [7:0]        ld_val1_reg;
    logic [IDX_W-1:0]  cy1_reg;
    logic [IDX_W-1:0]  cz1_reg;
    logic [FRAC_W-1:0] fx1_reg;
    logic [FRAC_W-1:0] fy1_reg;
    logic [FRAC_W-1:0] fz1_reg;
    logic [7:0]        p1_reg [2];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cmd1_reg    <= cmd0;
            ld_idx1_reg <= ld_idx0;
            ld_val1_reg <= ld_val0;
            cy1_reg     <= sum_y[FRAC_BITS +: IDX_W];
            cz1_reg     <= sum_z[FRAC_BITS +: IDX_W];
            fx1_reg     <= sum_x[FRAC_W-1:0];
            fy1_reg     <= sum_y[FRAC_W-1:0];
            fz1_reg     <= sum_z[FRAC_W-1:0];
        end
    end

    // First table copy, read at the x cell and its neighbor.
    logic [7:0] perm0_mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready && cmd0 == CMD_LOAD)
            perm0_mem[ld_idx0] <= ld_val0;
        if (en[1])
        begin
            p1_reg[0] <= perm0_mem[cx0];
            p1_reg[1] <= perm0_mem[cx0 + IDX_W'(1)];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: second lookup level (a and b rows), fade squares.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  addr2 [2];
    logic [IDX_W-1:0]  ld_idx2_reg;
    logic [7:0]        ld_val2_reg;
    logic [IDX_W-1:0]  cz2_reg;
    logic [FRAC_W-1:0] fx2_reg;
    logic [FRAC_W-1:0] fy2_reg;
    logic [FRAC_W-1:0] fz2_reg;
    logic [FRAC_W-1:0] sqx2_reg;
    logic [FRAC_W-1:0] sqy2_reg;
    logic [FRAC_W-1:0] sqz2_reg;
    logic [7:0]        p2_reg [2][2];
    logic              wr2;

    assign addr2[0] = IDX_W'(p1_reg[0]) + cy1_reg;
    assign addr2[1] = IDX_W'(p1_reg[1]) + cy1_reg;
    assign wr2      = en[2] && v_reg[1] && cmd1_reg == CMD_LOAD;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cmd2_reg    <= cmd1_reg;
            ld_idx2_reg <= ld_idx1_reg;
            ld_val2_reg <= ld_val1_reg;
            cz2_reg     <= cz1_reg;
            fx2_reg     <= fx1_reg;
            fy2_reg     <= fy1_reg;
            fz2_reg     <= fz1_reg;
            sqx2_reg    <= FRAC_W'((2*FRAC_W)'(fx1_reg) * (2*FRAC_W)'(fx1_reg) >> FRAC_BITS);
            sqy2_reg    <= FRAC_W'((2*FRAC_W)'(fy1_reg) * (2*FRAC_W)'(fy1_reg) >> FRAC_BITS);
            sqz2_reg    <= FRAC_W'((2*FRAC_W)'(fz1_reg) * (2*FRAC_W)'(fz1_reg) >> FRAC_BITS);
        end
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_row
        logic [7:0] perm_mem [TABLE_SIZE];
        always_ff @(posedge clk)
        begin
            if (wr2)
                perm_mem[ld_idx1_reg] <= ld_val1_reg;
            if (en[2])
            begin
                p2_reg[i][0] <= perm_mem[addr2[i]];
                p2_reg[i][1] <= perm_mem[addr2[i] + IDX_W'(1)];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: corner hashes, fade cube and weight polynomial.
    // Bank j serves aa, ab, ba, bb; slot 0 is the z0 corner, slot 1 z1.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]        addr3 [4];
    logic [7:0]              h3_reg [2][4];
    logic [FRAC_W-1:0]       fx3_reg;
    logic [FRAC_W-1:0]       fy3_reg;
    logic [FRAC_W-1:0]       fz3_reg;
    logic [FRAC_W-1:0]       cube3_reg [3];
    logic [WGT_W-1:0]        wgt3_reg [3];
    logic [FRAC_W-1:0]       sq2 [3];
    logic [FRAC_W-1:0]       fr2 [3];
    logic signed [WGT_W+1:0] wgt2 [3];
    logic                    wr3;

    assign sq2 = '{sqx2_reg, sqy2_reg, sqz2_reg};
    assign fr2 = '{fx2_reg, fy2_reg, fz2_reg};
    assign wr3 = en[3] && v_reg[2] && cmd2_reg == CMD_LOAD;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            addr3[j] = IDX_W'(p2_reg[j / 2][j % 2]) + cz2_reg;
        // w = 6p - 15f + 10, always positive and below 2^(FRAC_BITS+4).
        for (int a = 0; a < 3; a++)
            wgt2[a] = (WGT_W+2)'(6) * $signed({2'b00, WGT_W'(sq2[a])})
                    - (WGT_W+2)'(15) * $signed({2'b00, WGT_W'(fr2[a])})
                    + (WGT_W+2)'(10 * ONE_FX);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
            fz3_reg <= fz2_reg;
            for (int a = 0; a < 3; a++)
            begin
                cube3_reg[a] <= FRAC_W'((2*FRAC_W)'(sq2[a]) * (2*FRAC_W)'(fr2[a])
                                        >> FRAC_BITS);
                wgt3_reg[a]  <= wgt2[a][WGT_W-1:0];
            end
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_corner
        logic [7:0] perm_mem [TABLE_SIZE];
        always_ff @(posedge clk)
        begin
            if (wr3)
                perm_mem[ld_idx2_reg] <= ld_val2_reg;
            if (en[3])
            begin
                h3_reg[0][j] <= perm_mem[addr3[j]];
                h3_reg[1][j] <= perm_mem[addr3[j] + IDX_W'(1)];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 -> 4: fade result and the eight gradient dot products.
    // Gradient index is z*4 + x*2 + y.
    // ------------------------------------------------------------------
    logic signed [DELTA_W-1:0] dx [2];
    logic signed [DELTA_W-1:0] dy [2];
    logic signed [DELTA_W-1:0] dz [2];
    logic [FADE_W-1:0]         fade3 [3];
    logic [FRAC_W+WGT_W-1:0]   cw3 [3];
    logic signed [GRAD_W-1:0]  g4_reg [8];
    logic [FADE_W-1:0]         fade4_reg [3];

    always_comb
    begin
        dx[0] = $signed(DELTA_W'(fx3_reg));
        dx[1] = $signed(DELTA_W'(fx3_reg)) - DELTA_W'(ONE_FX);
        dy[0] = $signed(DELTA_W'(fy3_reg));
        dy[1] = $signed(DELTA_W'(fy3_reg)) - DELTA_W'(ONE_FX);
        dz[0] = $signed(DELTA_W'(fz3_reg));
        dz[1] = $signed(DELTA_W'(fz3_reg)) - DELTA_W'(ONE_FX);
        for (int a = 0; a < 3; a++)
        begin
            cw3[a] = (FRAC_W+WGT_W)'(cube3_reg[a]) * (FRAC_W+WGT_W)'(wgt3_reg[a])
                   + (FRAC_W+WGT_W)'(HALF_FX);
            if (cw3[a][FRAC_W+WGT_W-1:FRAC_BITS] > WGT_W'(ONE_FX))
                fade3[a] = FADE_W'(ONE_FX);
            else
                fade3[a] = cw3[a][FRAC_BITS +: FADE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            fade4_reg <= fade3;
            for (int k = 0; k < 8; k++)
                g4_reg[k] <= grad_dot(h3_reg[k / 4][k % 4][3:0],
                                      dx[(k / 2) % 2], dy[k % 2], dz[k / 4]);
        end
    end

    // ------------------------------------------------------------------
    // Stages 5..10: three lerp levels, each a product stage and a round/add
    // stage; the last round/add is clamped into the output register.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] px5_reg [4];
    logic signed [VAL_W-1:0]  ax5_reg [4];
    logic [FADE_W-1:0]        fy5_reg;
    logic [FADE_W-1:0]        fz5_reg;
    logic signed [VAL_W-1:0]  n6_reg [4];
    logic [FADE_W-1:0]        fy6_reg;
    logic [FADE_W-1:0]        fz6_reg;
    logic signed [PROD_W-1:0] py7_reg [2];
    logic signed [VAL_W-1:0]  ay7_reg [2];
    logic [FADE_W-1:0]        fz7_reg;
    logic signed [VAL_W-1:0]  m8_reg [2];
    logic [FADE_W-1:0]        fz8_reg;
    logic signed [PROD_W-1:0] pz9_reg;
    logic signed [VAL_W-1:0]  az9_reg;
    logic signed [VAL_W-1:0]  r9;
    logic [NOISE_W-1:0]       noise_reg;

    always_ff @(posedge clk)
    begin
        // x lerp: pair k takes corners (z, x=0, y) and (z, x=1, y), k = {z, y}.
        if (en[5])
        begin
            fy5_reg <= fade4_reg[1];
            fz5_reg <= fade4_reg[2];
            for (int k = 0; k < 4; k++)
            begin
                ax5_reg[k] <= VAL_W'(g4_reg[(k / 2) * 4 + k % 2]);
                px5_reg[k] <= PROD_W'($signed({1'b0, fade4_reg[0]})
                              * (VAL_W'(g4_reg[(k / 2) * 4 + 2 + k % 2])
                                 - VAL_W'(g4_reg[(k / 2) * 4 + k % 2])));
            end
        end
        if (en[6])
        begin
            fy6_reg <= fy5_reg;
            fz6_reg <= fz5_reg;
            for (int k = 0; k < 4; k++)
                n6_reg[k] <= ax5_reg[k] + round_frac(px5_reg[k]);
        end
        // y lerp: n00 with n10 gives lo, n01 with n11 gives hi.
        if (en[7])
        begin
            fz7_reg <= fz6_reg;
            for (int k = 0; k < 2; k++)
            begin
                ay7_reg[k] <= n6_reg[2 * k];
                py7_reg[k] <= PROD_W'($signed({1'b0, fy6_reg})
                              * (n6_reg[2 * k + 1] - n6_reg[2 * k]));
            end
        end
        if (en[8])
        begin
            fz8_reg <= fz7_reg;
            for (int k = 0; k < 2; k++)
                m8_reg[k] <= ay7_reg[k] + round_frac(py7_reg[k]);
        end
        // z lerp.
        if (en[9])
        begin
            az9_reg <= m8_reg[0];
            pz9_reg <= PROD_W'($signed({1'b0, fz8_reg}) * (m8_reg[1] - m8_reg[0]));
        end
        if (en[10])
        begin
            if (r9 > VAL_W'(2 * ONE_FX))
                noise_reg <= NOISE_W'(2 * ONE_FX);
            else if (r9 < -VAL_W'(2 * ONE_FX))
                noise_reg <= NOISE_W'(-2 * ONE_FX);
            else
                noise_reg <= r9[NOISE_W-1:0];
        end
    end

    assign r9 = az9_reg + round_frac(pz9_reg);

    assign m_tvalid = v_reg[10];
    assign m_tdata  = {(24 - NOISE_W)'(0), noise_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CHK_SAME(a_stall_from_output, !s_tready, m_tvalid && !m_tready,
              "input stalled while the output side is not stalled")
    `CHK_SAME(a_noise_clamped, m_tvalid,
              $signed(noise_reg) <= $signed(NOISE_W'(2 * ONE_FX))
              && $signed(noise_reg) >= $signed(NOISE_W'(-2 * ONE_FX)),
              "noise result outside the clamp range")
    `CHK_SAME(a_fade_bounded, v_reg[5],
              fy5_reg <= FADE_W'(ONE_FX) && fz5_reg <= FADE_W'(ONE_FX),
              "fade weight above one")
    `CHK_NEXT(a_load_dropped, en[3] && v_reg[2] && cmd2_reg == CMD_LOAD, !v_reg[3],
              "table load entered the arithmetic stages")

endmodule

`default_nettype wire
